### rtl/cylinder_point_query_unit_defines.svh
// Assertion macros used by the checker in cpq_checker.sv.
`ifndef CYLINDER_POINT_QUERY_UNIT_DEFINES_SVH
`define CYLINDER_POINT_QUERY_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define CPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define CPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");
`endif

### rtl/cpq_pkg.sv
// ----------------------------------------------------------------------------
// cpq_pkg
// Types and constants shared by the cylinder point query block.
// ----------------------------------------------------------------------------
`default_nettype none
package cpq_pkg;
	localparam int COORD_W = 16;
	localparam int IDX_W = 10;
	localparam int CFG_W = 16;
	localparam int DIST_W = 37;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_HMIN = 2'd1,
		REG_HMAX = 2'd2,
		REG_SAMPLES = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [47:0] rot_row0;
		logic [47:0] rot_row1;
		logic [47:0] rot_row2;
	} in_item_t;

	typedef struct packed {
		logic [9:0] point_index;
		logic real_hit;
		logic last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_query;  // latch center and rotation, empty nearest list
		logic issue;       // issue a point read into the pipeline
		logic emit_load;   // load output register with current slot
		logic slot_adv;    // advance emitted slot
	} cpq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;   // last point issued
		logic pipe_empty;  // no point in flight
		logic slot_last;   // current slot is the final one
	} cpq_sts_t;
endpackage
`default_nettype wire

### rtl/cpq_datapath.sv
// ----------------------------------------------------------------------------
// cpq_datapath
// Point store, transform pipeline, sorted nearest list and output slot logic.
// ----------------------------------------------------------------------------
`default_nettype none
module cpq_datapath #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_SAMPLES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cpq_pkg::in_item_t in_item,
	input wire logic in_xfer,
	input wire logic [14:0] radius,
	input wire logic signed [15:0] height_min,
	input wire logic signed [15:0] height_max,
	input wire logic [6:0] sample_count,
	input wire cpq_pkg::cpq_cmd_t cmd,
	output cpq_pkg::cpq_sts_t sts,
	output cpq_pkg::out_item_t emit_item
);
	import cpq_pkg::*;

	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SW = $clog2(MAX_SAMPLES + 1);
	localparam int LW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	logic [47:0] mem [MAX_POINTS];
	logic [PW-1:0] total_q, rd_ptr_q;
	logic [AW-1:0] wr_addr;

	assign wr_addr = total_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer && in_item.action == ACT_APPEND && total_q < PW'(MAX_POINTS)) begin
			mem[wr_addr] <= {in_item.pos_z, in_item.pos_y, in_item.pos_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (in_xfer && in_item.action == ACT_CLEAR) begin
			total_q <= '0;
		end else if (in_xfer && in_item.action == ACT_APPEND && total_q < PW'(MAX_POINTS)) begin
			total_q <= total_q + 1'b1;
		end
	end

	// query registers
	logic signed [15:0] cx_q, cy_q, cz_q;
	logic [47:0] row_q [3];
	logic [SW-1:0] cap_q;
	logic [35:0] r2_q;

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			cx_q <= in_item.pos_x;
			cy_q <= in_item.pos_y;
			cz_q <= in_item.pos_z;
			row_q[0] <= in_item.rot_row0;
			row_q[1] <= in_item.rot_row1;
			row_q[2] <= in_item.rot_row2;
			r2_q <= 36'(radius) * 36'(radius);
			if (sample_count == 7'd0) begin
				cap_q <= SW'(1);
			end else if (32'(sample_count) > MAX_SAMPLES) begin
				cap_q <= SW'(MAX_SAMPLES);
			end else begin
				cap_q <= SW'(sample_count);
			end
		end
	end

	// stage 1: read point
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic [47:0] pt_s1;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
		end else if (cmd.load_query) begin
			rd_ptr_q <= '0;
		end else if (cmd.issue && !sts.scan_done) begin
			rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	assign sts.scan_done = (rd_ptr_q >= total_q);

	always_ff @(posedge clk) begin
		pt_s1 <= mem[rd_ptr_q[AW-1:0]];
		idx_s1 <= rd_ptr_q[AW-1:0];
	end

	// stage 2: relative position
	logic signed [16:0] rel_s2 [3];
	always_ff @(posedge clk) begin
		rel_s2[0] <= 17'(signed'(pt_s1[15:0])) - 17'(cx_q);
		rel_s2[1] <= 17'(signed'(pt_s1[31:16])) - 17'(cy_q);
		rel_s2[2] <= 17'(signed'(pt_s1[47:32])) - 17'(cz_q);
		idx_s2 <= idx_s1;
	end

	// stage 3: nine products
	logic signed [32:0] prod_s3 [3][3];
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s3[r][c] <= 33'(signed'(row_q[r][16*c +: 16])) * 33'(rel_s2[c]);
			end
		end
		idx_s3 <= idx_s2;
	end

	// stage 4: row sums, shift, saturate
	logic signed [17:0] loc_s4 [3];
	logic signed [17:0] loc_c [3];
	always_comb begin
		logic signed [34:0] sum;
		logic signed [20:0] q;
		for (int r = 0; r < 3; r++) begin
			sum = 35'(prod_s3[r][0]) + 35'(prod_s3[r][1]) + 35'(prod_s3[r][2]);
			q = sum[34:14];
			if (q > 21'sd131071) begin
				loc_c[r] = 18'sd131071;
			end else if (q < -21'sd131072) begin
				loc_c[r] = -18'sd131072;
			end else begin
				loc_c[r] = q[17:0];
			end
		end
	end
	always_ff @(posedge clk) begin
		loc_s4 <= loc_c;
		idx_s4 <= idx_s3;
	end

	// stage 5: squares and bounds
	logic [35:0] sy_s5, sz_s5;
	logic xin_s5;
	always_ff @(posedge clk) begin
		sy_s5 <= 36'(loc_s4[1] * loc_s4[1]);
		sz_s5 <= 36'(loc_s4[2] * loc_s4[2]);
		xin_s5 <= (loc_s4[0] > 18'(height_min)) && (loc_s4[0] < 18'(height_max));
		idx_s5 <= idx_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			v1_s1 <= cmd.issue && !sts.scan_done;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
		end
	end
	assign sts.pipe_empty = !(v1_s1 || v2_s2 || v3_s3 || v4_s4 || v5_s5);

	// insertion into sorted list: each entry decides locally
	logic [DIST_W-1:0] pt_dist;
	logic hit;
	assign pt_dist = DIST_W'(sy_s5) + DIST_W'(sz_s5);
	assign hit = v5_s5 && xin_s5 && (pt_dist < DIST_W'(r2_q));

	logic [DIST_W-1:0] nd_q [MAX_SAMPLES];
	logic [AW-1:0] ni_q [MAX_SAMPLES];
	logic [SW-1:0] hits_q;
	logic [MAX_SAMPLES-1:0] gt;

	always_comb begin
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			gt[i] = (SW'(i) < hits_q) && (nd_q[i] > pt_dist);
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			for (int i = 0; i < MAX_SAMPLES; i++) begin
				if (SW'(i) < cap_q) begin
					if (gt[i]) begin
						if (i == 0 || !gt[(i > 0) ? i - 1 : 0]) begin
							nd_q[i] <= pt_dist;
							ni_q[i] <= idx_s5;
						end else begin
							nd_q[i] <= nd_q[(i > 0) ? i - 1 : 0];
							ni_q[i] <= ni_q[(i > 0) ? i - 1 : 0];
						end
					end else if (SW'(i) == hits_q) begin
						// the first free entry takes the old tail when the new hit goes before it
						if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
							nd_q[i] <= nd_q[(i > 0) ? i - 1 : 0];
							ni_q[i] <= ni_q[(i > 0) ? i - 1 : 0];
						end else begin
							nd_q[i] <= pt_dist;
							ni_q[i] <= idx_s5;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (cmd.load_query) begin
			hits_q <= '0;
		end else if (hit && hits_q < cap_q) begin
			hits_q <= hits_q + 1'b1;
		end
	end

	// output slots
	logic [SW-1:0] slot_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.load_query) begin
			slot_q <= '0;
		end else if (cmd.slot_adv) begin
			slot_q <= slot_q + 1'b1;
		end
	end
	assign sts.slot_last = (slot_q + 1'b1 == cap_q);

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			if (slot_q < hits_q) begin
				emit_item.point_index <= IDX_W'(ni_q[slot_q[LW-1:0]]);
				emit_item.real_hit <= 1'b1;
			end else begin
				emit_item.point_index <= (hits_q != '0) ? IDX_W'(ni_q[0]) : '0;
				emit_item.real_hit <= 1'b0;
			end
			emit_item.last <= sts.slot_last;
		end
	end
endmodule
`default_nettype wire

### rtl/cpq_ctrl.sv
// ----------------------------------------------------------------------------
// cpq_ctrl
// Sequencer for point loads, query scan and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
module cpq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [1:0] in_action,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire cpq_pkg::cpq_sts_t sts,
	output cpq_pkg::cpq_cmd_t cmd
);
	import cpq_pkg::*;

	state_t state_q, state_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q;
		cmd = '0;
		in_ready = 1'b0;
		if (ov_q && out_ready) begin
			ov_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_action == ACT_QUERY) begin
					cmd.load_query = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!ov_q || out_ready) begin
					cmd.emit_load = 1'b1;
					cmd.slot_adv = 1'b1;
					ov_d = 1'b1;
					if (sts.slot_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/cylinder_point_query_unit.sv
// ----------------------------------------------------------------------------
// cylinder_point_query_unit
// Stores points and returns the nearest hits inside a rotated cylinder.
// ----------------------------------------------------------------------------
// Clear and append items are accepted only in the idle state. A query scans
// every stored point, up to MAX_POINTS of them (one point read per cycle from
// the point memory, through a five-stage transform pipeline), then emits one
// index per output transfer, sample_count transfers in all, with sample_count
// clamped to the range 1 to MAX_SAMPLES.
`default_nettype none
module cylinder_point_query_unit #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_SAMPLES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cpq_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output cpq_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import cpq_pkg::*;

	logic [14:0] radius_q;
	logic signed [15:0] hmin_q, hmax_q;
	logic [6:0] samples_q;
	cpq_cmd_t cmd;
	cpq_sts_t sts;
	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 15'd4096;
			hmin_q <= '0;
			hmax_q <= 16'sd4096;
			samples_q <= 7'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[14:0];
				REG_HMIN: hmin_q <= cfg_data;
				REG_HMAX: hmax_q <= cfg_data;
				REG_SAMPLES: samples_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	cpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_action(in_data.action),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	cpq_datapath #(.MAX_POINTS(MAX_POINTS), .MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .in_xfer(in_xfer),
		.radius(radius_q), .height_min(hmin_q), .height_max(hmax_q),
		.sample_count(samples_q), .cmd(cmd), .sts(sts), .emit_item(out_data)
	);
endmodule
`default_nettype wire

### rtl/cpq_checker.sv
// ----------------------------------------------------------------------------
// cpq_checker
// Port-level checks for the cylinder point query unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cylinder_point_query_unit_defines.svh"
module cpq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last
);
	// no new item while results are still pending
	`CPQ_ASSERT_IMP(a_no_in_while_out, clk, arst_n, out_valid && !out_last, !in_ready)
	// stalled output holds
	`CPQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// after a last transfer, no further result appears next cycle
	`CPQ_ASSERT_NXT(a_last_gap, clk, arst_n, out_valid && out_ready && out_last, !out_valid)
endmodule
bind cylinder_point_query_unit cpq_checker u_cpq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_last(out_data.last)
);
`default_nettype wire
